FILE: sv/grst_pkg.sv
`timescale 1ns / 1ps
package grst_pkg;

  localparam int SLOTS   = 1024;
  localparam int IDX_W   = 10;
  localparam int GEN_W   = 16;
  localparam int TOK_W   = 64;
  localparam int SER_W   = 64;
  localparam int DEPTH_W = 11;
  localparam int REJ_W   = 32;

  // commands
  localparam logic [2:0] CMD_ALLOC    = 3'd0;
  localparam logic [2:0] CMD_RESIDENT = 3'd1;
  localparam logic [2:0] CMD_EVICT    = 3'd2;
  localparam logic [2:0] CMD_RELEASE  = 3'd3;
  localparam logic [2:0] CMD_COLLECT  = 3'd4;
  localparam logic [2:0] CMD_SHADER   = 3'd5;
  localparam logic [2:0] CMD_TOKEN    = 3'd6;
  localparam logic [2:0] CMD_STATE    = 3'd7;

  // slot states
  localparam logic [1:0] ST_FALLBACK = 2'd0;
  localparam logic [1:0] ST_RESIDENT = 2'd1;
  localparam logic [1:0] ST_NONRES   = 2'd2;
  localparam logic [1:0] ST_RETIRED  = 2'd3;

  // result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_REJECT    = 2'd1;
  localparam logic [1:0] STS_EXHAUSTED = 2'd2;

  localparam int SLOT_W = TOK_W + SER_W + GEN_W + 2;

  typedef struct packed {
    logic [TOK_W-1:0] token;
    logic [SER_W-1:0] serial;
    logic [GEN_W-1:0] gen;
    logic [1:0]       st;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic pop;
    logic exec;
    logic sweep_rd;
    logic sweep_wr;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic stack_empty;
    logic out_free;
    logic ptr_last;
  } sts_t;

endpackage

FILE: sv/grst_ram.sv
`timescale 1ns / 1ps
module grst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

FILE: sv/grst_ctrl.sv
`timescale 1ns / 1ps
module grst_ctrl import grst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_stall,
  input  sts_t       sts,
  output ctl_t       ctl
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_SWRD  = 3'd4;
  localparam logic [2:0] S_SWWR  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          ctl.accept = 1'b1;
          if (in_cmd == CMD_ALLOC && !sts.stack_empty) state_nxt = S_POP;
          else if (in_cmd == CMD_COLLECT) state_nxt = S_SWRD;
          else state_nxt = S_EXEC;
        end
      end
      S_POP: begin
        ctl.pop   = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) begin
          ctl.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWRD: begin
        ctl.sweep_rd = 1'b1;
        state_nxt    = S_SWWR;
      end
      S_SWWR: begin
        ctl.sweep_wr = 1'b1;
        state_nxt    = sts.ptr_last ? S_EXEC : S_SWRD;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/grst_dp.sv
`timescale 1ns / 1ps
module grst_dp import grst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_t               ctl,
  output sts_t               sts,
  input  logic [2:0]         in_cmd,
  input  logic [IDX_W-1:0]   in_handle_index,
  input  logic [GEN_W-1:0]   in_handle_generation,
  input  logic [TOK_W-1:0]   in_token,
  input  logic [SER_W-1:0]   in_serial,
  input  logic               cfg_we,
  input  logic [TOK_W-1:0]   cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_index,
  output logic [GEN_W-1:0]   out_generation,
  output logic [TOK_W-1:0]   out_token,
  output logic [1:0]         out_state,
  output logic [IDX_W-1:0]   out_resident_count,
  output logic [IDX_W-1:0]   out_nonresident_count,
  output logic [IDX_W-1:0]   out_retired_count,
  output logic [REJ_W-1:0]   out_stale_rejections,
  output logic [DEPTH_W-1:0] out_high_watermark
);

  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  // latched item
  logic [2:0]       cmd_r;
  logic [IDX_W-1:0] idx_r, sidx_r;
  logic [GEN_W-1:0] gen_r;
  logic [TOK_W-1:0] tok_r;
  logic [SER_W-1:0] ser_r;
  logic             exh_r;

  logic [TOK_W-1:0]   fallback_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [IDX_W-1:0]   res_r, non_r, ret_r, res_nxt, non_nxt, ret_nxt;
  logic [REJ_W-1:0]   rej_r, rej_nxt;
  logic [DEPTH_W-1:0] wm_r, wm_nxt;
  logic [IDX_W-1:0]   ptr_r;

  // ram ports
  logic             slot_we, slot_re;
  logic [IDX_W-1:0] slot_wa, slot_ra;
  slot_t            slot_wd, sd;
  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_wa, stk_ra, stk_wd, stk_rd;

  grst_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .wa(slot_wa), .wd(slot_wd),
    .re(slot_re), .ra(slot_ra), .rd(sd)
  );

  grst_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk(clk), .we(stk_we), .wa(stk_wa), .wd(stk_wd),
    .re(stk_re), .ra(stk_ra), .rd(stk_rd)
  );

  logic             ok, upd, rej_inc;
  logic [1:0]       old_st, new_st;
  logic [1:0]       r_status, r_state;
  logic [IDX_W-1:0] r_index;
  logic [GEN_W-1:0] r_gen;
  logic [TOK_W-1:0] r_tok;
  logic             sweep_hit;
  logic [DEPTH_W-1:0] sidx_p1;

  assign ok = (gen_r != '0) && (idx_r != '0) && (sd.gen == gen_r) && (sd.st != ST_RETIRED);
  assign sweep_hit = (sd.st == ST_RETIRED) && (sd.serial <= ser_r);
  assign sidx_p1   = DEPTH_W'(sidx_r) + DEPTH_W'(1);

  assign sts.stack_empty = (depth_r == '0);
  assign sts.out_free    = !out_valid || !out_stall;
  assign sts.ptr_last    = (ptr_r == IDX_W'(SLOTS - 1));

  // ram addressing, slot update and result forming
  always_comb begin
    slot_we  = 1'b0;
    slot_wa  = ptr_r;
    slot_wd  = sd;
    slot_re  = 1'b0;
    slot_ra  = in_handle_index;
    stk_we   = 1'b0;
    stk_wa   = ptr_r;
    stk_wd   = IDX_W'(SLOTS - 1) - ptr_r;
    stk_re   = 1'b0;
    stk_ra   = depth_nxt[IDX_W-1:0];
    depth_nxt = depth_r;
    upd      = 1'b0;
    old_st   = sd.st;
    new_st   = sd.st;
    rej_inc  = 1'b0;
    wm_nxt   = wm_r;
    r_status = STS_OK;
    r_index  = '0;
    r_gen    = '0;
    r_tok    = '0;
    r_state  = ST_FALLBACK;

    // clearing pass after reset
    if (ctl.clear) begin
      slot_we       = 1'b1;
      slot_wd.token = '0;
      slot_wd.serial = '0;
      slot_wd.gen   = GEN_W'(1);
      slot_wd.st    = (ptr_r == '0) ? ST_FALLBACK : ST_NONRES;
      stk_we        = 1'b1;
    end

    // issue reads for a new item
    if (ctl.accept) begin
      slot_re = (in_cmd != CMD_ALLOC);
      if (in_cmd == CMD_ALLOC && depth_r != '0) begin
        depth_nxt = depth_r - DEPTH_W'(1);
        stk_re    = 1'b1;
      end
    end

    // popped index is known, read its slot
    if (ctl.pop) begin
      slot_re = 1'b1;
      slot_ra = stk_rd;
    end

    if (ctl.sweep_rd) begin
      slot_re = 1'b1;
      slot_ra = ptr_r;
    end

    // one slot of the collect sweep
    if (ctl.sweep_wr && sweep_hit) begin
      slot_we        = 1'b1;
      slot_wa        = ptr_r;
      slot_wd.serial = '0;
      slot_wd.gen    = (sd.gen == GEN_MAX) ? GEN_W'(1) : sd.gen + GEN_W'(1);
      slot_wd.st     = ST_NONRES;
      upd            = 1'b1;
      new_st         = ST_NONRES;
      if (depth_r < DEPTH_W'(SLOTS)) begin
        stk_we    = 1'b1;
        stk_wa    = depth_r[IDX_W-1:0];
        stk_wd    = ptr_r;
        depth_nxt = depth_r + DEPTH_W'(1);
      end
    end

    // command execution
    if (ctl.exec) begin
      slot_wa = idx_r;
      case (cmd_r)
        CMD_ALLOC: begin
          if (exh_r) begin
            r_status = STS_EXHAUSTED;
          end else begin
            slot_we        = 1'b1;
            slot_wa        = sidx_r;
            slot_wd.token  = tok_r;
            slot_wd.serial = '0;
            slot_wd.st     = (tok_r == '0) ? ST_NONRES : ST_RESIDENT;
            upd            = 1'b1;
            new_st         = slot_wd.st;
            r_index        = sidx_r;
            r_gen          = sd.gen;
            if (sidx_p1 > wm_r) wm_nxt = sidx_p1;
          end
        end
        CMD_RESIDENT: begin
          if (!ok || tok_r == '0) begin
            rej_inc  = 1'b1;
            r_status = STS_REJECT;
          end else begin
            slot_we       = 1'b1;
            slot_wd.token = tok_r;
            slot_wd.st    = ST_RESIDENT;
            upd           = 1'b1;
            new_st        = ST_RESIDENT;
          end
        end
        CMD_EVICT: begin
          if (!ok) begin
            rej_inc  = 1'b1;
            r_status = STS_REJECT;
          end else begin
            slot_we       = 1'b1;
            slot_wd.token = '0;
            slot_wd.st    = ST_NONRES;
            upd           = 1'b1;
            new_st        = ST_NONRES;
          end
        end
        CMD_RELEASE: begin
          if (!ok) begin
            rej_inc  = 1'b1;
            r_status = STS_REJECT;
          end else begin
            slot_we        = 1'b1;
            slot_wd.token  = '0;
            slot_wd.serial = ser_r;
            slot_wd.st     = ST_RETIRED;
            upd            = 1'b1;
            new_st         = ST_RETIRED;
          end
        end
        CMD_COLLECT: begin
          r_status = STS_OK;
        end
        CMD_SHADER: begin
          r_index = (ok && sd.st == ST_RESIDENT) ? idx_r : '0;
        end
        CMD_TOKEN: begin
          r_tok = (idx_r == '0 || sd.st != ST_RESIDENT) ? fallback_r : sd.token;
        end
        CMD_STATE: begin
          r_state = ok ? sd.st : ST_FALLBACK;
        end
        default: r_status = STS_OK;
      endcase
    end

    // live counters follow the state change
    res_nxt = res_r;
    non_nxt = non_r;
    ret_nxt = ret_r;
    if (upd) begin
      res_nxt = res_r + IDX_W'(new_st == ST_RESIDENT) - IDX_W'(old_st == ST_RESIDENT);
      non_nxt = non_r + IDX_W'(new_st == ST_NONRES) - IDX_W'(old_st == ST_NONRES);
      ret_nxt = ret_r + IDX_W'(new_st == ST_RETIRED) - IDX_W'(old_st == ST_RETIRED);
    end
    rej_nxt = rej_r + REJ_W'(rej_inc);
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fallback_r <= TOK_W'(1);
      depth_r    <= DEPTH_W'(SLOTS - 1);
      res_r      <= '0;
      non_r      <= IDX_W'(SLOTS - 1);
      ret_r      <= '0;
      rej_r      <= '0;
      wm_r       <= '0;
      ptr_r      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we && cfg_wdata != '0) fallback_r <= cfg_wdata;
      depth_r <= depth_nxt;
      res_r   <= res_nxt;
      non_r   <= non_nxt;
      ret_r   <= ret_nxt;
      rej_r   <= rej_nxt;
      wm_r    <= wm_nxt;
      if (ctl.clear || ctl.sweep_wr) ptr_r <= ptr_r + IDX_W'(1);
      else if (ctl.accept) ptr_r <= IDX_W'(1);
      if (ctl.exec) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= in_cmd;
      idx_r <= in_handle_index;
      gen_r <= in_handle_generation;
      tok_r <= in_token;
      ser_r <= in_serial;
      exh_r <= (depth_r == '0);
    end
    if (ctl.pop) sidx_r <= stk_rd;
    if (ctl.exec) begin
      out_status            <= r_status;
      out_index             <= r_index;
      out_generation        <= r_gen;
      out_token             <= r_tok;
      out_state             <= r_state;
      out_resident_count    <= res_nxt;
      out_nonresident_count <= non_nxt;
      out_retired_count     <= ret_nxt;
      out_stale_rejections  <= rej_nxt;
      out_high_watermark    <= wm_nxt;
    end
  end

endmodule

FILE: sv/generational_residency_slot_table.sv
`timescale 1ns / 1ps
// the result is registered in EXEC after the input transfer; an alloc with
// a free slot goes through POP first; EXEC waits while the previous result
// sits stalled on the output. a new item is taken only once the previous
// result is registered. collect reads and writes back slots 1..1023 in turn
// reset: synchronous active low; a clearing pass of the slot and free-stack
// memories follows, input stalled meanwhile, config writes taken
module generational_residency_slot_table import grst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic [IDX_W-1:0]   in_handle_index,
  input  logic [GEN_W-1:0]   in_handle_generation,
  input  logic [TOK_W-1:0]   in_token,
  input  logic [SER_W-1:0]   in_serial,
  input  logic               cfg_we,
  input  logic [TOK_W-1:0]   cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_index,
  output logic [GEN_W-1:0]   out_generation,
  output logic [TOK_W-1:0]   out_token,
  output logic [1:0]         out_state,
  output logic [IDX_W-1:0]   out_resident_count,
  output logic [IDX_W-1:0]   out_nonresident_count,
  output logic [IDX_W-1:0]   out_retired_count,
  output logic [REJ_W-1:0]   out_stale_rejections,
  output logic [DEPTH_W-1:0] out_high_watermark
);

  ctl_t ctl;
  sts_t sts;

  grst_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_cmd),
    .in_stall(in_stall), .sts(sts), .ctl(ctl)
  );

  grst_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_cmd), .in_handle_index(in_handle_index),
    .in_handle_generation(in_handle_generation), .in_token(in_token),
    .in_serial(in_serial), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_index(out_index), .out_generation(out_generation),
    .out_token(out_token), .out_state(out_state),
    .out_resident_count(out_resident_count),
    .out_nonresident_count(out_nonresident_count),
    .out_retired_count(out_retired_count),
    .out_stale_rejections(out_stale_rejections),
    .out_high_watermark(out_high_watermark)
  );

endmodule

FILE: sv/grst_chk.sv
`timescale 1ns / 1ps
module grst_chk import grst_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [IDX_W-1:0]   out_index,
  input logic [GEN_W-1:0]   out_generation,
  input logic [IDX_W-1:0]   out_resident_count,
  input logic [IDX_W-1:0]   out_nonresident_count,
  input logic [IDX_W-1:0]   out_retired_count
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_index))
    else $error("stalled result changed");

  // every slot but the fallback is in exactly one live state
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (12'(out_resident_count) + 12'(out_nonresident_count)
                   + 12'(out_retired_count)) == 12'(SLOTS - 1))
    else $error("live counts do not cover the table");

  // an exhausted alloc hands out no handle
  a_exh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_EXHAUSTED |-> out_index == '0 && out_generation == '0)
    else $error("exhausted alloc returned a handle");

  // no unused status code
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");

  // input held off as the clearing pass starts after reset
  a_clr: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

endmodule

bind generational_residency_slot_table grst_chk u_grst_chk (.*);
